### hdl/masked_byte_pattern_search_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the masked byte pattern search core
// Shared helpers that clock properties on i_clk and disable them in reset.
// ----------------------------------------------------------------------------
`ifndef MASKED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SEARCH_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MBPS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define MBPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/mbps_pkg.sv
// ----------------------------------------------------------------------------
// mbps_pkg
// Types, widths and command codes shared by the pattern search core files.
// ----------------------------------------------------------------------------
package mbps_pkg;

    // Number of pattern cells in the ring.
    localparam int MAX_PATTERN = 64;

    localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
    localparam int CFG_W  = 7;
    localparam int PIDX_W = 6;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 32;
    localparam int CMD_W  = 2;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 72;

    localparam logic [CMD_W-1:0] CMD_NEW_SEARCH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NEW_SECTION = 2'd1;
    localparam logic [CMD_W-1:0] CMD_LOAD        = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SCAN        = 2'd3;

    typedef struct packed {
        logic [7:0] pbyte;
        logic       care;
    } t_pat_ent;

    typedef struct packed {
        logic shift;
        logic rotate;
        logic load;
    } t_cell_ctrl;

    // Packed so that window_match lands in bit 0.
    typedef struct packed {
        logic [ADDR_W-1:0] first_match_address;
        logic              found;
        logic [CNT_W-1:0]  match_count;
        logic              window_match;
    } t_result;

endpackage

### hdl/mbps_cell.sv
// ----------------------------------------------------------------------------
// mbps_cell
// One window position: a byte of the stream chain, one pattern ring entry,
// and the registered compare between the two.
// ----------------------------------------------------------------------------
module mbps_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbps_pkg::t_cell_ctrl i_ctrl,
    input  logic [7:0]          i_byte,
    output logic [7:0]          o_byte,
    input  mbps_pkg::t_pat_ent  i_rot,
    input  mbps_pkg::t_pat_ent  i_load,
    output mbps_pkg::t_pat_ent  o_pat,
    input  logic                i_in_win,
    output logic                o_hit
);

    logic [7:0] r_byte;
    logic [7:0] r_pbyte;
    logic       r_care;
    logic       r_hit;
    logic       n_hit;

    // The compare looks at the byte arriving in this cycle.
    assign n_hit = !i_in_win || !r_care || (i_byte == r_pbyte);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_byte <= i_byte;
            r_hit  <= n_hit;
        end
        if (i_ctrl.rotate) begin
            r_pbyte <= i_rot.pbyte;
        end else if (i_ctrl.load) begin
            r_pbyte <= i_load.pbyte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_care <= 1'b0;
        end else if (i_ctrl.rotate) begin
            r_care <= i_rot.care;
        end else if (i_ctrl.load) begin
            r_care <= i_load.care;
        end
    end

    assign o_byte      = r_byte;
    assign o_pat.pbyte = r_pbyte;
    assign o_pat.care  = r_care;
    assign o_hit       = r_hit;

endmodule

### hdl/mbps_tally.sv
// ----------------------------------------------------------------------------
// mbps_tally
// Reduces the cell compares to one match and keeps the search totals.
// ----------------------------------------------------------------------------
module mbps_tally (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_adv,
    input  logic [mbps_pkg::CMD_W-1:0]           i_cmd,
    input  logic                                 i_full,
    input  logic [mbps_pkg::MAX_PATTERN-1:0]     i_hits,
    input  logic [mbps_pkg::ADDR_W-1:0]          i_start,
    output mbps_pkg::t_result                    o_res
);

    logic [mbps_pkg::CNT_W-1:0]  r_count;
    logic [mbps_pkg::CNT_W-1:0]  n_count;
    logic                        r_found;
    logic                        n_found;
    logic [mbps_pkg::ADDR_W-1:0] r_first;
    logic [mbps_pkg::ADDR_W-1:0] n_first;
    logic                        hit;

    assign hit = (i_cmd == mbps_pkg::CMD_SCAN) && i_full && (&i_hits);

    always_comb begin
        n_count = r_count;
        n_found = r_found;
        n_first = r_first;
        if (i_cmd == mbps_pkg::CMD_NEW_SEARCH) begin
            n_count = '0;
            n_found = 1'b0;
            n_first = '0;
        end else if (hit) begin
            if (!r_found) begin
                n_found = 1'b1;
                n_first = i_start;
            end
            if (r_count != '1) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_found <= 1'b0;
            r_first <= '0;
        end else if (i_adv) begin
            r_count <= n_count;
            r_found <= n_found;
            r_first <= n_first;
        end
    end

    assign o_res.window_match        = hit;
    assign o_res.match_count         = n_count;
    assign o_res.found               = n_found;
    assign o_res.first_match_address = n_first;

endmodule

### hdl/masked_byte_pattern_search_core.sv
// ----------------------------------------------------------------------------
// masked_byte_pattern_search_core
// Wildcard byte signature scanner built as a chain of window cells.
//
//   Channel     | Dir | Handshake              | Payload
//   ------------+-----+------------------------+-------------------------------
//   slave word  | in  | i_s_tvalid/o_s_tready  | i_s_tdata (48b), i_s_tuser
//   master word | out | o_m_tvalid/i_m_tready  | o_m_tdata (72b)
//   config      | in  | i_cfg_wen              | i_cfg_wdata (pattern_length)
//
// Every accepted word yields exactly one result word; a new word can be taken in
// every cycle unless the ring rotates or the master side stalls. The cells register
// their compare in the accept cycle and the tally reduces them into r_out.
// After a pattern_length write the pattern ring rotates one cell per cycle to
// realign with the new length, with o_s_tready low until it is aligned.
// Reset is synchronous and active low; it sets pattern_length to 1 and clears
// the care bits, the totals and the window fill.
// A stalled master side holds the result word and backs up into o_s_tready.
// ----------------------------------------------------------------------------
module masked_byte_pattern_search_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Slave word: i_s_tdata = data_byte[7:0], care_bit[8], pattern_index[14:9],
    // byte_address[46:15], zero pad [47].
    input  logic                                  i_s_tvalid,
    output logic                                  o_s_tready,
    input  logic [mbps_pkg::IN_TDATA_W-1:0]       i_s_tdata,
    // i_s_tuser = command[1:0].
    input  logic [mbps_pkg::CMD_W-1:0]            i_s_tuser,
    // Master word: o_m_tdata = window_match[0], match_count[32:1], found[33],
    // first_match_address[65:34], zero pad [71:66].
    output logic                                  o_m_tvalid,
    input  logic                                  i_m_tready,
    output logic [mbps_pkg::OUT_TDATA_W-1:0]      o_m_tdata,
    // Configuration: pattern_length.
    input  logic                                  i_cfg_wen,
    input  logic [mbps_pkg::CFG_W-1:0]            i_cfg_wdata
);

    localparam int MAXP   = mbps_pkg::MAX_PATTERN;
    localparam int IDX_W  = mbps_pkg::IDX_W;
    localparam int LEN_W  = mbps_pkg::LEN_W;
    localparam int CFG_W  = mbps_pkg::CFG_W;
    localparam int PIDX_W = mbps_pkg::PIDX_W;
    localparam int ADDR_W = mbps_pkg::ADDR_W;
    localparam int LCMP_W = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int POS_W  = ((IDX_W > PIDX_W) ? IDX_W : PIDX_W) + 1;

    // Input word unpacking.
    logic [mbps_pkg::CMD_W-1:0] cmd;
    logic [7:0]                 in_byte;
    logic                       in_care;
    logic [PIDX_W-1:0]          in_idx;
    logic [ADDR_W-1:0]          in_addr;

    assign cmd     = i_s_tuser;
    assign in_byte = i_s_tdata[7:0];
    assign in_care = i_s_tdata[8];
    assign in_idx  = i_s_tdata[9 +: PIDX_W];
    assign in_addr = i_s_tdata[15 +: ADDR_W];

    // Pattern length register and its clamped form.
    logic [CFG_W-1:0]  r_pat_len;
    logic [LCMP_W-1:0] len_ext;
    logic [LEN_W-1:0]  act_len;
    logic [IDX_W-1:0]  tgt_align;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= CFG_W'(1);
        end else if (i_cfg_wen) begin
            r_pat_len <= i_cfg_wdata;
        end
    end

    always_comb begin
        len_ext = LCMP_W'(r_pat_len);
        if (len_ext == '0) begin
            act_len = LEN_W'(1);
        end else if (len_ext > LCMP_W'(MAXP)) begin
            act_len = LEN_W'(MAXP);
        end else begin
            act_len = LEN_W'(len_ext);
        end
    end

    assign tgt_align = IDX_W'(act_len - LEN_W'(1));

    // The pattern ring holds cell k = pattern[(r_align - k) mod MAX_PATTERN],
    // so cell k always faces the window byte k places back from the newest.
    // A length change is a rotation of the ring, one step per cycle.
    logic [IDX_W-1:0] r_align;
    logic             rotating;

    assign rotating = (r_align != tgt_align);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align <= '0;
        end else if (rotating) begin
            if (r_align == IDX_W'(MAXP - 1)) begin
                r_align <= '0;
            end else begin
                r_align <= r_align + 1'b1;
            end
        end
    end

    // Pipeline control.
    logic r_s2_vld;
    logic r_out_vld;
    logic s2_adv;
    logic s_acc;

    assign s2_adv     = r_s2_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !rotating && (!r_s2_vld || s2_adv);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // Section fill count, saturating at the window depth.
    logic [LEN_W-1:0] r_fill;
    logic [LEN_W-1:0] n_fill;

    always_comb begin
        n_fill = r_fill;
        case (cmd)
            mbps_pkg::CMD_NEW_SEARCH,
            mbps_pkg::CMD_NEW_SECTION: begin
                n_fill = '0;
            end
            mbps_pkg::CMD_SCAN: begin
                if (r_fill != LEN_W'(MAXP)) begin
                    n_fill = r_fill + 1'b1;
                end
            end
            default: begin
                n_fill = r_fill;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (s_acc) begin
            r_fill <= n_fill;
        end
    end

    // Ring position written by a pattern load.
    logic             idx_ok;
    logic [POS_W-1:0] pos_a;
    logic [POS_W-1:0] pos_i;
    logic [POS_W-1:0] pos_w;
    logic [IDX_W-1:0] load_pos;

    assign idx_ok = (POS_W'(in_idx) < POS_W'(MAXP));
    assign pos_a  = POS_W'(r_align);
    assign pos_i  = POS_W'(in_idx);
    assign pos_w  = (pos_a >= pos_i) ? (pos_a - pos_i) : (pos_a + POS_W'(MAXP) - pos_i);
    assign load_pos = IDX_W'(pos_w);

    logic do_shift;
    logic do_load;

    assign do_shift = s_acc && (cmd == mbps_pkg::CMD_SCAN);
    assign do_load  = s_acc && (cmd == mbps_pkg::CMD_LOAD) && idx_ok;

    mbps_pkg::t_pat_ent load_ent;

    assign load_ent.pbyte = in_byte;
    assign load_ent.care  = in_care;

    // The cell chain.
    logic [7:0]           cell_byte [MAXP];
    mbps_pkg::t_pat_ent   cell_pat  [MAXP];
    logic [MAXP-1:0]      cell_hit;

    for (genvar k = 0; k < MAXP; k++) begin : g_cell
        mbps_pkg::t_cell_ctrl ctrl;
        logic [7:0]           byte_in;
        mbps_pkg::t_pat_ent   rot_in;
        logic                 in_win;

        assign ctrl.shift  = do_shift;
        assign ctrl.rotate = rotating;
        assign ctrl.load   = do_load && (load_pos == IDX_W'(k));
        assign in_win      = (LEN_W'(k) < act_len);

        if (k == 0) begin : g_head
            assign byte_in = in_byte;
            assign rot_in  = cell_pat[MAXP-1];
        end else begin : g_body
            assign byte_in = cell_byte[k-1];
            assign rot_in  = cell_pat[k-1];
        end

        mbps_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_ctrl   (ctrl),
            .i_byte   (byte_in),
            .o_byte   (cell_byte[k]),
            .i_rot    (rot_in),
            .i_load   (load_ent),
            .o_pat    (cell_pat[k]),
            .i_in_win (in_win),
            .o_hit    (cell_hit[k])
        );
    end

    // Second stage: the word whose cell compares are now registered.
    logic [mbps_pkg::CMD_W-1:0] r_s2_cmd;
    logic                       r_s2_full;
    logic [ADDR_W-1:0]          r_s2_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else if (s_acc) begin
            r_s2_vld <= 1'b1;
        end else if (s2_adv) begin
            r_s2_vld <= 1'b0;
        end
    end

    // The match start is the address of the oldest byte in the window.
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s2_cmd   <= cmd;
            r_s2_full  <= (n_fill >= act_len);
            r_s2_start <= in_addr - ADDR_W'(act_len) + ADDR_W'(1);
        end
    end

    mbps_pkg::t_result tally_res;

    mbps_tally u_tally (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (s2_adv),
        .i_cmd   (r_s2_cmd),
        .i_full  (r_s2_full),
        .i_hits  (cell_hit),
        .i_start (r_s2_start),
        .o_res   (tally_res)
    );

    // Output register.
    mbps_pkg::t_result r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s2_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_adv) begin
            r_out <= tally_res;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = mbps_pkg::OUT_TDATA_W'(r_out);

    // Assertions.
    `include "masked_byte_pattern_search_core_assert.svh"

    `MBPS_ASSERT_SAME(a_no_accept_while_rotating, rotating, !o_s_tready, "word taken during ring rotation")
    `MBPS_ASSERT_SAME(a_match_sets_found, r_out_vld && r_out.window_match, r_out.found, "match without found flag")
    `MBPS_ASSERT_SAME(a_match_counts, r_out_vld && r_out.window_match, r_out.match_count != '0, "match with zero count")
    `MBPS_ASSERT_SAME(a_fill_bound, 1'b1, r_fill <= LEN_W'(MAXP), "window fill beyond depth")
    `MBPS_ASSERT_NEXT(a_load_keeps_align, do_load, r_align == $past(r_align), "ring moved on a pattern load")

endmodule
